@@ hw/rtl/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
package ple_pkg;

   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_BACK  = 3'd1;
   localparam logic [2:0] CMD_INS_AT    = 3'd2;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
   localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
   localparam logic [2:0] CMD_DEL_AT    = 3'd5;
   localparam logic [2:0] CMD_READ_OUT  = 3'd6;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_BADPOS = 2'd1;
   localparam logic [1:0] STAT_EMPTY  = 2'd2;
   localparam logic [1:0] STAT_FULL   = 2'd3;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
      logic [5:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] element;
      logic [5:0]         count;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic exec_edit;
      logic rd_start;
      logic rd_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic list_empty;
      logic rd_last;
   } dp_stat_type;

endpackage

@@ hw/rtl/ple_ctrl.sv @@
// Control state machine for the positional list engine.
module ple_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_command,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ple_pkg::ctl_cmd_type ctl_cmd,
   input  ple_pkg::dp_stat_type dp_stat
);
   import ple_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;
   logic      go_read;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign go_read   = accept && (req_command == CMD_READ_OUT) && !dp_stat.list_empty;

   assign ctl_cmd.exec_edit = accept && !go_read;
   assign ctl_cmd.rd_start  = go_read;
   assign ctl_cmd.rd_step   = (state_ff == S_READ) && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (go_read) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (ctl_cmd.rd_step && dp_stat.rd_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (ctl_cmd.exec_edit || ctl_cmd.rd_step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctl_cmd.exec_edit || ctl_cmd.rd_step) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while a word is still waiting");
   a_busy_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !req_ready)
      else $error("request taken during read out");
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      !(ctl_cmd.exec_edit && ctl_cmd.rd_step))
      else $error("edit and read out step issued together");
   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.rd_start |=> (state_ff == S_READ))
      else $error("read out start did not enter read state");
`endif

endmodule

@@ hw/rtl/ple_dp.sv @@
// Datapath of the positional list engine: cell row, count, read counter and result register.
module ple_dp #(
   parameter int CAPACITY = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ple_pkg::req_type     req_payload,
   input  ple_pkg::ctl_cmd_type ctl_cmd,
   output ple_pkg::dp_stat_type dp_stat,
   output ple_pkg::rsp_type     rsp_payload
);
   import ple_pkg::*;

   localparam int LIMIT = (CAPACITY < 63) ? CAPACITY : 63;

   logic signed [31:0] cells_ff [CAPACITY];
   logic signed [31:0] cells_in [CAPACITY];
   logic [5:0]         count_ff, count_in;
   logic [5:0]         rd_cnt_ff, rd_cnt_in;
   rsp_type            rsp_ff, rsp_in;

   logic [6:0] count7;
   logic [6:0] pos7;
   logic       is_full;
   logic       is_empty;
   logic       do_ins;
   logic       do_del;
   logic [5:0] idx;
   logic [1:0] status;
   logic [5:0] new_count;

   assign count7   = {1'b0, count_ff};
   assign pos7     = {1'b0, req_payload.position};
   assign is_full  = count7 >= 7'(LIMIT);
   assign is_empty = (count_ff == 6'd0);

   always_comb begin
      do_ins = 1'b0;
      do_del = 1'b0;
      idx    = 6'd0;
      status = STAT_OK;
      case (req_payload.command)
         CMD_INS_FRONT, CMD_INS_BACK: begin
            if (is_full) begin
               status = STAT_FULL;
            end else begin
               do_ins = 1'b1;
               idx    = (req_payload.command == CMD_INS_FRONT) ? 6'd0 : count_ff;
            end
         end
         CMD_INS_AT: begin
            if ((pos7 == 7'd0) || (pos7 > count7 + 7'd1)) begin
               status = STAT_BADPOS;
            end else if (is_full) begin
               status = STAT_FULL;
            end else begin
               do_ins = 1'b1;
               idx    = req_payload.position - 6'd1;
            end
         end
         CMD_DEL_FRONT, CMD_DEL_BACK: begin
            if (is_empty) begin
               status = STAT_EMPTY;
            end else begin
               do_del = 1'b1;
               idx    = (req_payload.command == CMD_DEL_FRONT) ? 6'd0 : count_ff - 6'd1;
            end
         end
         CMD_DEL_AT: begin
            if (is_empty) begin
               status = STAT_EMPTY;
            end else if ((pos7 == 7'd0) || (pos7 > count7)) begin
               status = STAT_BADPOS;
            end else begin
               do_del = 1'b1;
               idx    = req_payload.position - 6'd1;
            end
         end
         CMD_READ_OUT: begin
            if (is_empty) begin
               status = STAT_EMPTY;
            end
         end
         default: begin
            status = STAT_OK;
         end
      endcase
   end

   assign new_count = do_ins ? count_ff + 6'd1 : (do_del ? count_ff - 6'd1 : count_ff);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [6:0] POS = 7'(i);
      logic signed [31:0] from_left;
      logic signed [31:0] from_right;

      if (i == 0) begin : g_first
         assign from_left = req_payload.value;
      end else begin : g_mid
         assign from_left = cells_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign from_right = cells_ff[i];
      end else begin : g_inner
         assign from_right = cells_ff[i+1];
      end

      always_comb begin
         cells_in[i] = cells_ff[i];
         if (ctl_cmd.exec_edit && do_ins && (POS >= {1'b0, idx})) begin
            cells_in[i] = (POS == {1'b0, idx}) ? req_payload.value : from_left;
         end else if (ctl_cmd.exec_edit && do_del && (POS >= {1'b0, idx})) begin
            cells_in[i] = from_right;
         end else if (ctl_cmd.rd_step) begin
            if (POS + 7'd1 < count7) begin
               cells_in[i] = from_right;
            end else if (POS + 7'd1 == count7) begin
               cells_in[i] = cells_ff[0];
            end
         end
      end

      always_ff @(posedge clock) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   always_comb begin
      count_in  = count_ff;
      rd_cnt_in = rd_cnt_ff;
      rsp_in    = rsp_ff;
      if (ctl_cmd.exec_edit) begin
         count_in       = new_count;
         rsp_in.element = '0;
         rsp_in.count   = new_count;
         rsp_in.status  = status;
         rsp_in.last    = 1'b1;
      end else if (ctl_cmd.rd_step) begin
         rd_cnt_in      = rd_cnt_ff + 6'd1;
         rsp_in.element = cells_ff[0];
         rsp_in.count   = count_ff;
         rsp_in.status  = STAT_OK;
         rsp_in.last    = dp_stat.rd_last;
      end
      if (ctl_cmd.rd_start) begin
         rd_cnt_in = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 6'd0;
         rd_cnt_ff <= 6'd0;
      end else begin
         count_ff  <= count_in;
         rd_cnt_ff <= rd_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign dp_stat.list_empty = is_empty;
   assign dp_stat.rd_last    = (rd_cnt_ff == count_ff - 6'd1);
   assign rsp_payload        = rsp_ff;

`ifndef SYNTHESIS
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count7 <= 7'(LIMIT))
      else $error("element count above list limit");
   a_step_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.rd_step |-> !is_empty)
      else $error("read out step on an empty list");
   a_step_keeps_count: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.rd_step |=> (count_ff == $past(count_ff)))
      else $error("read out changed the element count");
`endif

endmodule

@@ hw/rtl/positional_list_engine_core.sv @@
// Top level of the positional list engine.
// Keeps an ordered list of signed 32-bit values with an element count.
// Request words (req_valid/req_ready, req_payload) carry a command, a value
// and a 1-based position; response words (rsp_valid/rsp_ready, rsp_payload)
// carry an element, the new count, a status and a last flag.
// An edit command's single response word is in the output register the
// cycle after it is accepted; with a receiver that keeps up, one edit is
// accepted every cycle, since the next request is taken while the previous
// response is being taken.
// A read out of n elements is accepted and then loads one element word per
// step, each step rotating the cell row one place; no request is accepted
// until the last element word has been loaded.
// When the receiver stalls, the response word holds and no new request or
// read out step proceeds until the output register frees.
// Reset empties the list and drops any pending response; cell contents are
// not cleared and are never read before being written.
module positional_list_engine_core #(
   parameter int CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ple_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ple_pkg::rsp_type rsp_payload
);
   import ple_pkg::*;

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   ple_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_payload.command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .ctl_cmd     (ctl_cmd),
      .dp_stat     (dp_stat)
   );

   ple_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl_cmd     (ctl_cmd),
      .dp_stat     (dp_stat),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ tb/sv/tb_positional_list_engine_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the positional list engine core with random handshake gaps.
module tb_positional_list_engine_core;
   import ple_pkg::*;

   localparam int CAPACITY   = 32;
   localparam int LIST_LIMIT = (CAPACITY < 63) ? CAPACITY : 63;
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   req_type            pending_words[$];
   rsp_type            expected_words[$];
   logic signed [31:0] list_cells [0:CAPACITY-1];
   int                 list_len = 0;
   int                 error_count = 0;
   int                 req_hold = 0;
   int                 rsp_hold = 0;
   bit                 req_calm = 1'b0;
   bit                 rsp_calm = 1'b1;

   positional_list_engine_core #(.CAPACITY(CAPACITY)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #6000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void insert_cell(input int idx, input logic signed [31:0] v);
      for (int i = list_len; i > idx; i--)
         list_cells[i] = list_cells[i - 1];
      list_cells[idx] = v;
      list_len++;
   endfunction

   function automatic void remove_cell(input int idx);
      for (int i = idx; i + 1 < list_len; i++)
         list_cells[i] = list_cells[i + 1];
      list_len--;
   endfunction

   function automatic void predict_list(input req_type w);
      rsp_type r;
      r = '0;
      r.status = STAT_OK;
      r.last = 1'b1;
      case (w.command)
         CMD_INS_FRONT, CMD_INS_BACK: begin
            if (list_len >= LIST_LIMIT)
               r.status = STAT_FULL;
            else
               insert_cell((w.command == CMD_INS_FRONT) ? 0 : list_len, w.value);
         end
         CMD_INS_AT: begin
            if (w.position < 1 || w.position > list_len + 1)
               r.status = STAT_BADPOS;
            else if (list_len >= LIST_LIMIT)
               r.status = STAT_FULL;
            else
               insert_cell(w.position - 1, w.value);
         end
         CMD_DEL_FRONT, CMD_DEL_BACK: begin
            if (list_len == 0)
               r.status = STAT_EMPTY;
            else
               remove_cell((w.command == CMD_DEL_FRONT) ? 0 : list_len - 1);
         end
         CMD_DEL_AT: begin
            if (list_len == 0)
               r.status = STAT_EMPTY;
            else if (w.position < 1 || w.position > list_len)
               r.status = STAT_BADPOS;
            else
               remove_cell(w.position - 1);
         end
         CMD_READ_OUT: begin
            if (list_len == 0)
               r.status = STAT_EMPTY;
         end
         default: ;
      endcase
      r.count = 6'(list_len);
      if (w.command == CMD_READ_OUT && list_len > 0) begin
         for (int i = 0; i < list_len; i++) begin
            r.element = list_cells[i];
            r.last = (i == list_len - 1);
            expected_words.push_back(r);
         end
      end else begin
         expected_words.push_back(r);
      end
   endfunction

   task automatic check_word(input rsp_type seen);
      rsp_type want;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected word, element %0d count %0d status %0d last %0d",
                  $time, seen.element, seen.count, seen.status, seen.last);
         error_count++;
      end else begin
         want = expected_words.pop_front();
         if (seen.element !== want.element) begin
            $display("%0t: element expected %0d, got %0d", $time, want.element, seen.element);
            error_count++;
         end
         if (seen.count !== want.count) begin
            $display("%0t: count expected %0d, got %0d", $time, want.count, seen.count);
            error_count++;
         end
         if (seen.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, seen.status);
            error_count++;
         end
         if (seen.last !== want.last) begin
            $display("%0t: last expected %0d, got %0d", $time, want.last, seen.last);
            error_count++;
         end
      end
   endtask

   function automatic req_type make_word(input logic [2:0] cmd, input logic [31:0] val,
                                         input logic [5:0] pos);
      req_type w;
      w.command = cmd;
      w.value = val;
      w.position = pos;
      return w;
   endfunction

   // Phase 0 fills the list past full, phase 1 mixes all commands, phase 2 drains it.
   function automatic req_type random_word(input int phase);
      req_type w;
      int roll;
      w.value = $urandom();
      w.position = 6'($urandom_range(0, 63));
      roll = $urandom_range(0, 99);
      if (phase == 0) begin
         if (roll < 8)
            w.command = CMD_READ_OUT;
         else if (roll < 45)
            w.command = CMD_INS_FRONT;
         else if (roll < 85)
            w.command = CMD_INS_BACK;
         else begin
            w.command = CMD_INS_AT;
            w.position = 6'($urandom_range(1, 3));
         end
      end else if (phase == 1) begin
         if (roll < 12)
            w.command = CMD_READ_OUT;
         else if (roll < 26) begin
            w.command = CMD_INS_AT;
            w.position = 6'($urandom_range(1, 34));
         end else if (roll < 40) begin
            w.command = CMD_DEL_AT;
            w.position = 6'($urandom_range(1, 34));
         end else if (roll < 52)
            w.command = CMD_INS_FRONT;
         else if (roll < 64)
            w.command = CMD_INS_BACK;
         else if (roll < 76)
            w.command = CMD_DEL_FRONT;
         else if (roll < 88)
            w.command = CMD_DEL_BACK;
         else if (roll < 93)
            w.command = CMD_INS_AT;
         else if (roll < 98)
            w.command = CMD_DEL_AT;
         else
            w.command = CMD_UNUSED;
      end else begin
         if (roll < 8)
            w.command = CMD_READ_OUT;
         else if (roll < 40)
            w.command = CMD_DEL_FRONT;
         else if (roll < 75)
            w.command = CMD_DEL_BACK;
         else if (roll < 95) begin
            w.command = CMD_DEL_AT;
            w.position = 6'($urandom_range(1, 8));
         end else
            w.command = CMD_INS_AT;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      logic sent_now;
      if (reset) begin
         req_valid <= 1'b0;
         req_hold = 0;
      end else begin
         sent_now = req_valid && req_ready;
         if (sent_now) begin
            predict_list(req_payload);
            req_hold = req_calm ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 15) == 0)
               req_calm = !req_calm;
         end
         if (!req_valid || sent_now) begin
            if (req_hold > 0 || pending_words.size() == 0) begin
               req_valid <= 1'b0;
               if (req_hold > 0)
                  req_hold--;
            end else begin
               req_payload <= pending_words.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_word(rsp_payload);
            rsp_hold = rsp_calm ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 15) == 0)
               rsp_calm = !rsp_calm;
         end
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      pending_words.push_back(make_word(CMD_READ_OUT, $urandom(), 6'd0));
      pending_words.push_back(make_word(CMD_DEL_FRONT, $urandom(), 6'd1));
      pending_words.push_back(make_word(CMD_DEL_BACK, $urandom(), 6'd1));
      pending_words.push_back(make_word(CMD_DEL_AT, $urandom(), 6'd0));
      pending_words.push_back(make_word(CMD_DEL_AT, $urandom(), 6'd63));
      pending_words.push_back(make_word(CMD_INS_AT, 32'h1234_5678, 6'd0));
      pending_words.push_back(make_word(CMD_INS_AT, 32'h1234_5678, 6'd2));
      pending_words.push_back(make_word(CMD_INS_AT, 32'h7FFF_FFFF, 6'd1));
      pending_words.push_back(make_word(CMD_INS_FRONT, 32'h8000_0000, 6'd0));
      pending_words.push_back(make_word(CMD_INS_BACK, 32'hFFFF_FFFF, 6'd63));
      pending_words.push_back(make_word(CMD_INS_AT, 32'h0000_0000, 6'd4));
      pending_words.push_back(make_word(CMD_INS_AT, 32'hDEAD_BEEF, 6'd63));
      pending_words.push_back(make_word(CMD_INS_AT, 32'h5555_5555, 6'd2));
      pending_words.push_back(make_word(CMD_READ_OUT, $urandom(), 6'd5));
      pending_words.push_back(make_word(CMD_DEL_AT, $urandom(), 6'd0));
      pending_words.push_back(make_word(CMD_DEL_AT, $urandom(), 6'd6));
      pending_words.push_back(make_word(CMD_DEL_AT, $urandom(), 6'd3));
      pending_words.push_back(make_word(CMD_DEL_AT, $urandom(), 6'd4));
      pending_words.push_back(make_word(CMD_DEL_FRONT, $urandom(), 6'd0));
      pending_words.push_back(make_word(CMD_DEL_BACK, $urandom(), 6'd0));
      pending_words.push_back(make_word(CMD_UNUSED, $urandom(), 6'd63));
      pending_words.push_back(make_word(CMD_READ_OUT, $urandom(), 6'd0));
      pending_words.push_back(make_word(CMD_DEL_AT, $urandom(), 6'd1));
      for (int n = 0; n < 40; n++)
         pending_words.push_back(random_word(0));
      for (int n = 0; n < 32; n++)
         pending_words.push_back(random_word(1));
      for (int n = 0; n < 35; n++)
         pending_words.push_back(random_word(2));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
